FILE: design/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants
// Calibration word set, compensation-to-lookup word and fixed constants of the
// barometric compensation and altitude lookup block.
// ----------------------------------------------------------------------------
package bca_pkg;

  // Calibration register indexes
  localparam logic [2:0] CfgSens      = 3'd0;
  localparam logic [2:0] CfgOff       = 3'd1;
  localparam logic [2:0] CfgSensTemp  = 3'd2;
  localparam logic [2:0] CfgOffTemp   = 3'd3;
  localparam logic [2:0] CfgRefTemp   = 3'd4;
  localparam logic [2:0] CfgTempSlope = 3'd5;

  // Temperature offset, hundredths of a degree
  localparam logic signed [18:0] TempBase = 19'sd2000;
  // Pressure clamp ceiling for the lookup, in pascals
  localparam logic signed [25:0] PressMax      = 26'sd120000;
  localparam logic        [16:0] PressMaxIndex = 17'd120000;

  // Six calibration words
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
  } coeff_t;

  // Word handed from the compensation pipe to the lookup pipe
  typedef struct packed {
    logic               func;
    logic        [5:0]  entry_index;
    logic signed [20:0] entry_altitude;
    logic signed [18:0] temperature;
    logic signed [25:0] pressure;
  } link_word_t;

endpackage

FILE: design/bca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_if: channel interfaces
// Sample input, result output and calibration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface bca_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic        [5:0]  entry_index;
  logic signed [20:0] entry_altitude;
  logic        [23:0] raw_pressure;
  logic        [23:0] raw_temperature;

  modport source (output valid, func, entry_index, entry_altitude, raw_pressure,
                  raw_temperature, input ready);
  modport sink   (input valid, func, entry_index, entry_altitude, raw_pressure,
                  raw_temperature, output ready);
endinterface

interface bca_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] temperature;
  logic signed [31:0] pressure;
  logic signed [20:0] altitude;

  modport source (output valid, temperature, pressure, altitude, input ready);
  modport sink   (input valid, temperature, pressure, altitude, output ready);
endinterface

interface bca_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/bca_comp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_comp: first-order compensation pipeline
// Six stages: dT, three coefficient products, OFF/SENS/TEMP sums, split
// D1*SENS partial products, product merge, final shift and subtract.
// ----------------------------------------------------------------------------
module bca_comp (
  input  logic                clk_i,
  input  logic                rst_ni,
  bca_in_if.sink              sample_i,
  input  bca_pkg::coeff_t     coeff_i,
  output logic                link_valid_o,
  input  logic                link_ready_i,
  output bca_pkg::link_word_t link_word_o
);
  import bca_pkg::*;

  localparam int NumStages = 6;

  // Load fields ride along untouched
  typedef struct packed {
    logic               func;
    logic        [5:0]  entry_index;
    logic signed [20:0] entry_altitude;
  } side_t;

  logic [NumStages-1:0] v_q, en;
  side_t                side_q [NumStages];
  side_t                side_d;
  logic        [23:0]   d1_q [3];
  logic signed [24:0]   dt_q, dt_d;
  logic signed [41:0]   mt_q, mt_d, mo_q, mo_d, ms_q, ms_d;
  logic signed [18:0]   temp_q [4];
  logic signed [18:0]   temp_d;
  logic signed [36:0]   off_q [3];
  logic signed [36:0]   off_d;
  logic signed [35:0]   sens_q, sens_d;
  logic        [41:0]   pl_q, pl_d;
  logic signed [42:0]   ph_q, ph_d;
  logic signed [60:0]   prod_q, prod_d;
  logic signed [25:0]   press_q, press_d;

  // Stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || link_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign sample_i.ready = en[0];

  // Stage arithmetic
  assign side_d = '{func: sample_i.func, entry_index: sample_i.entry_index,
                    entry_altitude: sample_i.entry_altitude};
  assign dt_d   = $signed({1'b0, sample_i.raw_temperature})
                - $signed({1'b0, coeff_i.c5, 8'h00});
  assign mt_d   = dt_q * $signed({1'b0, coeff_i.c6});
  assign mo_d   = dt_q * $signed({1'b0, coeff_i.c4});
  assign ms_d   = dt_q * $signed({1'b0, coeff_i.c3});
  assign temp_d = 19'(mt_q >>> 23) + TempBase;
  assign off_d  = $signed({4'b0, coeff_i.c2, 17'b0}) + 37'(mo_q >>> 6);
  assign sens_d = $signed({4'b0, coeff_i.c1, 16'b0}) + 36'(ms_q >>> 7);
  // D1*SENS as two 24x18 partial products
  assign pl_d   = d1_q[2] * sens_q[17:0];
  assign ph_d   = $signed({1'b0, d1_q[2]}) * $signed(sens_q[35:18]);
  assign prod_d = (61'(ph_q) <<< 18) + $signed({19'b0, pl_q});
  assign press_d = 26'(((prod_q >>> 21) - 61'(off_q[2])) >>> 15);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= sample_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
      d1_q[0]   <= sample_i.raw_pressure;
      dt_q      <= dt_d;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
    if (en[1]) begin
      d1_q[1] <= d1_q[0];
      mt_q    <= mt_d;
      mo_q    <= mo_d;
      ms_q    <= ms_d;
    end
    if (en[2]) begin
      d1_q[2]   <= d1_q[1];
      temp_q[0] <= temp_d;
      off_q[0]  <= off_d;
      sens_q    <= sens_d;
    end
    if (en[3]) begin
      temp_q[1] <= temp_q[0];
      off_q[1]  <= off_q[0];
      pl_q      <= pl_d;
      ph_q      <= ph_d;
    end
    if (en[4]) begin
      temp_q[2] <= temp_q[1];
      off_q[2]  <= off_q[1];
      prod_q    <= prod_d;
    end
    if (en[5]) begin
      temp_q[3] <= temp_q[2];
      press_q   <= press_d;
    end
  end

  // Hand-off word
  assign link_valid_o = v_q[NumStages-1];
  always_comb begin
    link_word_o.func           = side_q[NumStages-1].func;
    link_word_o.entry_index    = side_q[NumStages-1].entry_index;
    link_word_o.entry_altitude = side_q[NumStages-1].entry_altitude;
    link_word_o.temperature    = temp_q[3];
    link_word_o.pressure       = press_q;
  end

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> v_q[0])
    else $error("accepted word missing from first stage");

  a_last_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NumStages-1] && !link_ready_i |=> v_q[NumStages-1] && $stable(press_q))
    else $error("stalled word lost in last compensation stage");

endmodule

FILE: design/bca_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_interp: altitude table and interpolation pipeline
// Clamps pressure, writes or reads the altitude table, then forms
// T0*S + (T1-T0)*f + S/2 over two more stages; the last is the output register.
// ----------------------------------------------------------------------------
module bca_interp #(
  parameter int FRAC_BITS   = 11,
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                link_valid_i,
  output logic                link_ready_o,
  input  bca_pkg::link_word_t link_word_i,
  bca_out_if.source           result_o
);
  import bca_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MulW  = FRAC_BITS + 23;
  localparam int AccW  = FRAC_BITS + 23;
  localparam logic signed [AccW-1:0] Half = AccW'(1 << (FRAC_BITS - 1));

  logic signed [20:0] mem_q [TABLE_DEPTH];

  logic                 en_a, en_b, en_c;
  logic                 va_q, vb_q, vc_q;
  logic        [16:0]   pc, idx0, idx1;
  logic                 ok0_d, ok1_d, ok0_q, ok1_q;
  logic        [AddrW-1:0] addr0, addr1, wr_addr;
  logic                 wr_en;
  logic signed [20:0]   rd0_q, rd1_q, t0, t1;
  logic [FRAC_BITS-1:0] frac_q;
  logic signed [18:0]   temp_a_q, temp_b_q, temp_c_q;
  logic signed [25:0]   press_a_q, press_b_q;
  logic signed [31:0]   press_c_q;
  logic signed [20:0]   t0_b_q;
  logic signed [21:0]   diff;
  logic signed [MulW-1:0] mul_q, mul_d;
  logic signed [AccW-1:0] acc_d;
  logic signed [20:0]   alt_d, alt_c_q;

  // Stall chain
  assign en_c         = !vc_q || result_o.ready;
  assign en_b         = !vb_q || en_c;
  assign en_a         = !va_q || en_b;
  assign link_ready_o = en_a;

  // Clamp and table indexes
  always_comb begin
    if (link_word_i.pressure < 0) begin
      pc = '0;
    end else if (link_word_i.pressure > PressMax) begin
      pc = PressMaxIndex;
    end else begin
      pc = 17'(link_word_i.pressure);
    end
    idx0  = pc >> FRAC_BITS;
    idx1  = idx0 + 17'd1;
    ok0_d = idx0 < 17'(TABLE_DEPTH);
    ok1_d = idx1 < 17'(TABLE_DEPTH);
    addr0 = idx0[AddrW-1:0];
    addr1 = idx1[AddrW-1:0];
  end

  // Load words write at the same hand-off where samples read
  assign wr_en   = en_a && link_valid_i && !link_word_i.func
                && (32'(link_word_i.entry_index) < 32'(TABLE_DEPTH));
  assign wr_addr = AddrW'(link_word_i.entry_index);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= link_word_i.entry_altitude;
    if (en_a) begin
      rd0_q <= mem_q[addr0];
      rd1_q <= mem_q[addr1];
    end
  end

  // Stage B: slope times fraction
  assign t0    = ok0_q ? rd0_q : '0;
  assign t1    = ok1_q ? rd1_q : '0;
  assign diff  = 22'(t1) - 22'(t0);
  assign mul_d = diff * $signed({1'b0, frac_q});

  // Stage C: base plus slope, rounded
  assign acc_d = (AccW'(t0_b_q) <<< FRAC_BITS) + AccW'(mul_q) + Half;
  assign alt_d = 21'(acc_d >>> FRAC_BITS);

  // Valid bits; load words leave the pipe here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= link_valid_i && link_word_i.func;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      ok0_q     <= ok0_d;
      ok1_q     <= ok1_d;
      frac_q    <= pc[FRAC_BITS-1:0];
      temp_a_q  <= link_word_i.temperature;
      press_a_q <= link_word_i.pressure;
    end
    if (en_b) begin
      t0_b_q    <= t0;
      mul_q     <= mul_d;
      temp_b_q  <= temp_a_q;
      press_b_q <= press_a_q;
    end
    if (en_c) begin
      alt_c_q   <= alt_d;
      temp_c_q  <= temp_b_q;
      press_c_q <= 32'(press_b_q);
    end
  end

  assign result_o.valid       = vc_q;
  assign result_o.temperature = temp_c_q;
  assign result_o.pressure    = press_c_q;
  assign result_o.altitude    = alt_c_q;

  a_upper_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q && ok1_q |-> ok0_q)
    else $error("upper table entry in range while lower is not");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_valid_i && link_ready_o && !link_word_i.func |=> !va_q)
    else $error("load word entered the lookup pipe");

  a_mid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !en_c |=> vb_q && $stable(mul_q))
    else $error("stalled word lost in interpolation stage");

endmodule

FILE: design/baro_compensate_to_altitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_compensate_to_altitude: barometric compensation with altitude lookup
// First-order pressure/temperature compensation from six calibration words,
// then clamp and linear interpolation in a loadable altitude table.
//
//   channel   dir  handshake     word
//   sample_i  in   valid/ready   func, entry index/altitude, raw P and T
//   result_o  out  valid/ready   temperature, pressure, altitude
//   cfg_i     in   valid/ready   register index, 16-bit data (always ready)
//
// Nine register stages (six compensation, three table read and interpolation).
// One word per cycle sustained while result_o is ready; the table has two read
// ports so both neighbor entries come out of one access.
// Reset clears valid bits and calibration words; the table is not cleared.
// A stall holds only the stages that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
module baro_compensate_to_altitude #(
  parameter int FRAC_BITS   = 11,
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bca_in_if.sink     sample_i,
  bca_out_if.source  result_o,
  bca_cfg_if.sink    cfg_i
);
  import bca_pkg::*;

  coeff_t     coeff_q, coeff_d;
  logic       link_valid, link_ready;
  link_word_t link_word;

  // Calibration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    coeff_d = coeff_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgSens:      coeff_d.c1 = cfg_i.data;
        CfgOff:       coeff_d.c2 = cfg_i.data;
        CfgSensTemp:  coeff_d.c3 = cfg_i.data;
        CfgOffTemp:   coeff_d.c4 = cfg_i.data;
        CfgRefTemp:   coeff_d.c5 = cfg_i.data;
        CfgTempSlope: coeff_d.c6 = cfg_i.data;
        default:      coeff_d = coeff_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  bca_comp u_comp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .coeff_i      (coeff_q),
    .link_valid_o (link_valid),
    .link_ready_i (link_ready),
    .link_word_o  (link_word)
  );

  bca_interp #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_interp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .link_valid_i (link_valid),
    .link_ready_o (link_ready),
    .link_word_i  (link_word),
    .result_o     (result_o)
  );

endmodule
